// File: src/coalescing_event_queue_assert.svh
// Assertion macros used by the coalescing event queue back end (ceq_back).
// Both sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef COALESCING_EVENT_QUEUE_ASSERT_SVH
`define COALESCING_EVENT_QUEUE_ASSERT_SVH

// Same-cycle property.
`define CEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle, consequence in the next.
`define CEQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: src/ceq_pkg.sv
// ----------------------------------------------------------------------------
// ceq_pkg
// Types and constants of the coalescing event queue: payload structs,
// operation, status and register codes, and the depths of the internal queues.
// ----------------------------------------------------------------------------
package ceq_pkg;

    localparam int RING_DEPTH_DEFAULT = 32;

    // Internal handoff queues; the depths must be powers of two.
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    localparam logic OP_POST = 1'b0;
    localparam logic OP_POLL = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESIZE_CODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOUSE_CODE  = 1'd1;
    localparam logic [7:0] RESIZE_CODE_RESET = 8'd1;
    localparam logic [7:0] MOUSE_CODE_RESET  = 8'd2;

    typedef logic [2:0] status_t;
    localparam status_t STATUS_APPENDED  = 3'd0;
    localparam status_t STATUS_MERGED    = 3'd1;
    localparam status_t STATUS_DROPPED   = 3'd2;
    localparam status_t STATUS_DELIVERED = 3'd3;
    localparam status_t STATUS_EMPTY     = 3'd4;

    typedef struct packed {
        logic              operation;
        logic [7:0]        event_kind;
        logic [15:0]       key_code;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [7:0]        button_bits;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [7:0]        out_kind;
        logic [15:0]       out_key;
        logic signed [11:0] out_x;
        logic signed [11:0] out_y;
        logic [7:0]        out_buttons;
    } out_item_t;

    typedef struct packed {
        logic [7:0]        kind;
        logic [15:0]       key;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [7:0]        buttons;
    } ring_entry_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        in_item_t item;
        logic     is_resize;
        logic     is_mouse;
    } cmd_t;

    typedef struct packed {
        logic [7:0] resize_code;
        logic [7:0] mouse_code;
    } codes_t;

endpackage

// File: src/ceq_front.sv
// ----------------------------------------------------------------------------
// ceq_front
// Input side: holds the event type codes, classifies each accepted item as
// resize and/or mouse, and queues it for the back end.
// ----------------------------------------------------------------------------
module ceq_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  ceq_pkg::in_item_t                   event_item,
    input  logic                                cfg_write,
    input  logic [ceq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ceq_pkg::CFG_DATA_W-1:0]      cfg_data,
    output ceq_pkg::codes_t                     codes,
    output logic                                cmd_valid,
    output ceq_pkg::cmd_t                       cmd_head,
    input  logic                                cmd_pop
);

    localparam int PTR_W = $clog2(ceq_pkg::CMD_DEPTH);
    localparam int CNT_W = $clog2(ceq_pkg::CMD_DEPTH + 1);

    ceq_pkg::codes_t    codes_reg;
    ceq_pkg::cmd_t      cmd_mem [ceq_pkg::CMD_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               take;
    ceq_pkg::cmd_t      cmd_new;

    assign full      = (count_reg == CNT_W'(ceq_pkg::CMD_DEPTH));
    assign take      = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd_head  = cmd_mem[rptr_reg];
    assign codes     = codes_reg;

    always_comb
    begin
        cmd_new.item      = event_item;
        cmd_new.is_resize = (event_item.event_kind == codes_reg.resize_code);
        cmd_new.is_mouse  = (event_item.event_kind == codes_reg.mouse_code);
    end

    always_comb
    begin
        wptr_next  = take    ? PTR_W'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next  = cmd_pop ? PTR_W'(rptr_reg + 1'b1) : rptr_reg;
        count_next = count_reg;
        case ({take, cmd_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
            codes_reg.resize_code <= ceq_pkg::RESIZE_CODE_RESET;
            codes_reg.mouse_code  <= ceq_pkg::MOUSE_CODE_RESET;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    ceq_pkg::CFG_RESIZE_CODE: codes_reg.resize_code <= cfg_data;
                    ceq_pkg::CFG_MOUSE_CODE:  codes_reg.mouse_code  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_mem[wptr_reg] <= cmd_new;
    end

endmodule

// File: src/ceq_back.sv
// ----------------------------------------------------------------------------
// ceq_back
// Execution side: owns the event ring, runs the coalescing sequence for each
// command (scan, last-entry check, append or drop, poll) and queues results.
// ----------------------------------------------------------------------------
`include "coalescing_event_queue_assert.svh"

module ceq_back #(
    parameter int RING_DEPTH = ceq_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ceq_pkg::codes_t     codes,
    input  logic                cmd_valid,
    input  ceq_pkg::cmd_t       cmd_head,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output ceq_pkg::out_item_t  result
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(RING_DEPTH - 1);
    localparam int RPTR_W = $clog2(ceq_pkg::RES_DEPTH);
    localparam int RCNT_W = $clog2(ceq_pkg::RES_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_SCAN     = 4'b0010,
        ST_LAST_CHK = 4'b0100,
        ST_POLL_OUT = 4'b1000
    } state_t;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_MAX) ? '0 : IDX_W'(i + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_MAX : IDX_W'(i - 1'b1);
    endfunction

    state_t                 state_reg, state_next;
    ceq_pkg::cmd_t          cmd_reg, cmd_next;
    logic [IDX_W-1:0]       rd_reg, rd_next;
    logic [IDX_W-1:0]       wr_reg, wr_next;
    logic [IDX_W-1:0]       scan_ptr_reg, scan_ptr_next;
    logic                   scan_mouse_reg, scan_mouse_next;
    logic                   rvalid_reg, rvalid_next;
    logic [IDX_W-1:0]       raddr_reg;
    ceq_pkg::ring_entry_t   rdata_reg;
    ceq_pkg::ring_entry_t   ring_mem [RING_DEPTH];

    logic [IDX_W-1:0]       rd_addr;
    logic                   ring_we;
    logic [IDX_W-1:0]       ring_waddr;
    ceq_pkg::ring_entry_t   ring_wdata;

    ceq_pkg::out_item_t     res_mem [ceq_pkg::RES_DEPTH];
    logic [RPTR_W-1:0]      res_wptr_reg, res_rptr_reg;
    logic [RCNT_W-1:0]      res_count_reg, res_count_next;
    logic                   res_push, res_pop, res_full;
    ceq_pkg::out_item_t     res_in;

    ceq_pkg::cmd_t          cur;
    logic                   ring_empty, ring_full;
    logic [7:0]             scan_code;

    assign ring_empty = (rd_reg == wr_reg);
    assign ring_full  = (idx_inc(wr_reg) == rd_reg);
    assign res_full   = (res_count_reg == RCNT_W'(ceq_pkg::RES_DEPTH));
    assign cur        = (state_reg == ST_IDLE) ? cmd_head : cmd_reg;
    assign scan_code  = scan_mouse_reg ? codes.mouse_code : codes.resize_code;

    always_comb
    begin
        logic go_tail;
        logic go_fill;

        go_tail         = 1'b0;
        go_fill         = 1'b0;
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        scan_ptr_next   = scan_ptr_reg;
        scan_mouse_next = scan_mouse_reg;
        rvalid_next     = 1'b0;
        rd_addr         = scan_ptr_reg;
        ring_we         = 1'b0;
        ring_waddr      = wr_reg;
        ring_wdata.kind    = cur.item.event_kind;
        ring_wdata.key     = cur.item.key_code;
        ring_wdata.x       = cur.item.pos_x;
        ring_wdata.y       = cur.item.pos_y;
        ring_wdata.buttons = cur.item.button_bits;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res_in          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // result slot is reserved before a command starts
                if (cmd_valid && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_head;
                    if (cmd_head.item.operation == ceq_pkg::OP_POLL)
                    begin
                        if (ring_empty)
                        begin
                            res_push      = 1'b1;
                            res_in.status = ceq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            rd_addr    = rd_reg;
                            state_next = ST_POLL_OUT;
                        end
                    end
                    else if (cmd_head.is_resize)
                    begin
                        state_next      = ST_SCAN;
                        scan_mouse_next = 1'b0;
                        scan_ptr_next   = rd_reg;
                    end
                    else
                    begin
                        go_tail = 1'b1;
                    end
                end
            end

            ST_SCAN:
            begin
                // one read issued per cycle; its data is checked in the next cycle
                if (rvalid_reg && (rdata_reg.kind == scan_code))
                begin
                    ring_we    = 1'b1;
                    ring_waddr = raddr_reg;
                    ring_wdata = rdata_reg;
                    ring_wdata.x = cur.item.pos_x;
                    ring_wdata.y = cur.item.pos_y;
                    if (scan_mouse_reg)
                        ring_wdata.buttons = cur.item.button_bits;
                    res_push      = 1'b1;
                    res_in.status = ceq_pkg::STATUS_MERGED;
                    state_next    = ST_IDLE;
                end
                else if (scan_ptr_reg != wr_reg)
                begin
                    rvalid_next   = 1'b1;
                    scan_ptr_next = idx_inc(scan_ptr_reg);
                end
                else if (scan_mouse_reg)
                begin
                    res_push      = 1'b1;
                    res_in.status = ceq_pkg::STATUS_DROPPED;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    go_tail = 1'b1;
                end
            end

            ST_LAST_CHK:
            begin
                if (rdata_reg.kind == codes.mouse_code)
                begin
                    ring_we    = 1'b1;
                    ring_waddr = raddr_reg;
                    ring_wdata = rdata_reg;
                    ring_wdata.x       = cur.item.pos_x;
                    ring_wdata.y       = cur.item.pos_y;
                    ring_wdata.buttons = cur.item.button_bits;
                    res_push      = 1'b1;
                    res_in.status = ceq_pkg::STATUS_MERGED;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    go_fill = 1'b1;
                end
            end

            ST_POLL_OUT:
            begin
                res_push           = 1'b1;
                res_in.status      = ceq_pkg::STATUS_DELIVERED;
                res_in.out_kind    = rdata_reg.kind;
                res_in.out_key     = rdata_reg.key;
                res_in.out_x       = rdata_reg.x;
                res_in.out_y       = rdata_reg.y;
                res_in.out_buttons = rdata_reg.buttons;
                rd_next            = idx_inc(rd_reg);
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // mouse event: look at the newest entry first
        if (go_tail)
        begin
            if (cur.is_mouse && !ring_empty)
            begin
                rd_addr    = idx_dec(wr_reg);
                state_next = ST_LAST_CHK;
            end
            else
            begin
                go_fill = 1'b1;
            end
        end

        if (go_fill)
        begin
            if (ring_full)
            begin
                if (cur.is_mouse)
                begin
                    state_next      = ST_SCAN;
                    scan_mouse_next = 1'b1;
                    scan_ptr_next   = rd_reg;
                end
                else
                begin
                    res_push      = 1'b1;
                    res_in.status = ceq_pkg::STATUS_DROPPED;
                    state_next    = ST_IDLE;
                end
            end
            else
            begin
                ring_we       = 1'b1;
                ring_waddr    = wr_reg;
                wr_next       = idx_inc(wr_reg);
                res_push      = 1'b1;
                res_in.status = ceq_pkg::STATUS_APPENDED;
                state_next    = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_reg         <= '0;
            wr_reg         <= '0;
            rvalid_reg     <= 1'b0;
            scan_mouse_reg <= 1'b0;
            scan_ptr_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            rvalid_reg     <= rvalid_next;
            scan_mouse_reg <= scan_mouse_next;
            scan_ptr_reg   <= scan_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        raddr_reg <= rd_addr;
    end

    // event ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ring_waddr] <= ring_wdata;
        rdata_reg <= ring_mem[rd_addr];
    end

    // result queue
    assign res_pop = pop && !empty;
    assign empty   = (res_count_reg == '0);
    assign result  = res_mem[res_rptr_reg];

    always_comb
    begin
        case ({res_push, res_pop})
            2'b10:   res_count_next = res_count_reg + 1'b1;
            2'b01:   res_count_next = res_count_reg - 1'b1;
            default: res_count_next = res_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wptr_reg  <= '0;
            res_rptr_reg  <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            res_count_reg <= res_count_next;
            if (res_push)
                res_wptr_reg <= RPTR_W'(res_wptr_reg + 1'b1);
            if (res_pop)
                res_rptr_reg <= RPTR_W'(res_rptr_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            res_mem[res_wptr_reg] <= res_in;
    end

    `CEQ_ASSERT(a_res_room, res_push |-> !res_full, "result pushed into a full queue")
    `CEQ_ASSERT(a_we_ends_item, ring_we |-> res_push, "ring write without a result")
    `CEQ_ASSERT_NEXT(a_poll_advance, res_push && (res_in.status == ceq_pkg::STATUS_DELIVERED), rd_reg != $past(rd_reg), "read index did not advance on delivery")

endmodule

// File: src/coalescing_event_queue.sv
// ----------------------------------------------------------------------------
// coalescing_event_queue
// Input-event ring for one window that merges resize and mouse events as
// they are posted; poll items pop the oldest event.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result in order. A resize event scans
// the ring for the oldest resize entry, and a mouse event that finds the ring
// full and the newest entry not a mouse event scans it for the oldest mouse
// entry. The scan cost comes from the ring's single registered read port, read
// one entry per cycle.
// Items wait in a two-entry command queue and results in a two-entry result
// queue, so push and pop may stall independently. The ring keeps one slot free
// and holds at most RING_DEPTH-1 events.
module coalescing_event_queue #(
    parameter int RING_DEPTH = ceq_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  ceq_pkg::in_item_t                   event_item,
    output logic                                empty,
    input  logic                                pop,
    output ceq_pkg::out_item_t                  result,
    input  logic                                cfg_write,
    input  logic [ceq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ceq_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ceq_pkg::codes_t codes;
    logic            cmd_valid;
    ceq_pkg::cmd_t   cmd_head;
    logic            cmd_pop;

    ceq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .event_item (event_item),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .codes      (codes),
        .cmd_valid  (cmd_valid),
        .cmd_head   (cmd_head),
        .cmd_pop    (cmd_pop)
    );

    ceq_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .codes      (codes),
        .cmd_valid  (cmd_valid),
        .cmd_head   (cmd_head),
        .cmd_pop    (cmd_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// File: sim/ceq_result_check.sv
// ----------------------------------------------------------------------------
// ceq_result_check
// Watches the event queue's push, pop and register ports, keeps a shadow copy
// of the ring and the type codes, and compares every popped result field by
// field with the oldest predicted one.
// ----------------------------------------------------------------------------
module ceq_result_check #(
    parameter int RING_DEPTH = ceq_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                full,
    input  ceq_pkg::in_item_t                   event_item,
    input  logic                                empty,
    input  logic                                pop,
    input  ceq_pkg::out_item_t                  result,
    input  logic                                cfg_write,
    input  logic [ceq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ceq_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  fail_count,
    output int                                  pending
);

    ceq_pkg::ring_entry_t shadow_ring [RING_DEPTH];
    int                   ring_rd;
    int                   ring_wr;
    logic [7:0]           resize_code_q;
    logic [7:0]           mouse_code_q;
    ceq_pkg::out_item_t   expected_results [$];
    int                   result_index;

    task automatic report_mismatch(string field, int unsigned want, int unsigned got);
        $display("result %0d: %s mismatch, expected %0h, got %0h",
                 result_index, field, want, got);
        fail_count++;
    endtask

    // Applies one accepted item to the shadow ring and returns its result.
    function automatic ceq_pkg::out_item_t apply_item(ceq_pkg::in_item_t it);
        ceq_pkg::out_item_t r;
        int                 i;
        int                 last;
        int                 nxt;
        r = '0;
        if (it.operation == ceq_pkg::OP_POLL)
        begin
            if (ring_rd == ring_wr)
            begin
                r.status = ceq_pkg::STATUS_EMPTY;
            end
            else
            begin
                r.status      = ceq_pkg::STATUS_DELIVERED;
                r.out_kind    = shadow_ring[ring_rd].kind;
                r.out_key     = shadow_ring[ring_rd].key;
                r.out_x       = shadow_ring[ring_rd].x;
                r.out_y       = shadow_ring[ring_rd].y;
                r.out_buttons = shadow_ring[ring_rd].buttons;
                ring_rd = (ring_rd + 1) % RING_DEPTH;
            end
            return r;
        end
        // resize: update the oldest queued resize, keep key and buttons
        if (it.event_kind == resize_code_q)
        begin
            for (i = ring_rd; i != ring_wr; i = (i + 1) % RING_DEPTH)
            begin
                if (shadow_ring[i].kind == resize_code_q)
                begin
                    shadow_ring[i].x = it.pos_x;
                    shadow_ring[i].y = it.pos_y;
                    r.status = ceq_pkg::STATUS_MERGED;
                    return r;
                end
            end
        end
        // mouse: fold into the newest entry if that one is a mouse event
        if (it.event_kind == mouse_code_q && ring_rd != ring_wr)
        begin
            last = (ring_wr + RING_DEPTH - 1) % RING_DEPTH;
            if (shadow_ring[last].kind == mouse_code_q)
            begin
                shadow_ring[last].x       = it.pos_x;
                shadow_ring[last].y       = it.pos_y;
                shadow_ring[last].buttons = it.button_bits;
                r.status = ceq_pkg::STATUS_MERGED;
                return r;
            end
        end
        nxt = (ring_wr + 1) % RING_DEPTH;
        if (nxt == ring_rd)
        begin
            // full ring: mouse lands on the oldest mouse entry, else drop
            if (it.event_kind == mouse_code_q)
            begin
                for (i = ring_rd; i != ring_wr; i = (i + 1) % RING_DEPTH)
                begin
                    if (shadow_ring[i].kind == mouse_code_q)
                    begin
                        shadow_ring[i].x       = it.pos_x;
                        shadow_ring[i].y       = it.pos_y;
                        shadow_ring[i].buttons = it.button_bits;
                        r.status = ceq_pkg::STATUS_MERGED;
                        return r;
                    end
                end
            end
            r.status = ceq_pkg::STATUS_DROPPED;
            return r;
        end
        shadow_ring[ring_wr].kind    = it.event_kind;
        shadow_ring[ring_wr].key     = it.key_code;
        shadow_ring[ring_wr].x       = it.pos_x;
        shadow_ring[ring_wr].y       = it.pos_y;
        shadow_ring[ring_wr].buttons = it.button_bits;
        ring_wr = nxt;
        r.status = ceq_pkg::STATUS_APPENDED;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ceq_pkg::out_item_t want;
        if (!rst_n)
        begin
            ring_rd       = 0;
            ring_wr       = 0;
            resize_code_q = ceq_pkg::RESIZE_CODE_RESET;
            mouse_code_q  = ceq_pkg::MOUSE_CODE_RESET;
            expected_results.delete();
            result_index  = 0;
            fail_count    = 0;
            pending       = 0;
        end
        else
        begin
            // pop side first: a result never comes from a same-edge push
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'd0, 32'(result.status));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(result.status));
                    if (result.out_kind !== want.out_kind)
                        report_mismatch("out_kind", 32'(want.out_kind),
                                        32'(result.out_kind));
                    if (result.out_key !== want.out_key)
                        report_mismatch("out_key", 32'(want.out_key), 32'(result.out_key));
                    if (result.out_x !== want.out_x)
                        report_mismatch("out_x", 32'(want.out_x[11:0]),
                                        32'(result.out_x[11:0]));
                    if (result.out_y !== want.out_y)
                        report_mismatch("out_y", 32'(want.out_y[11:0]),
                                        32'(result.out_y[11:0]));
                    if (result.out_buttons !== want.out_buttons)
                        report_mismatch("out_buttons", 32'(want.out_buttons),
                                        32'(result.out_buttons));
                end
                result_index++;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    ceq_pkg::CFG_RESIZE_CODE: resize_code_q = cfg_data;
                    ceq_pkg::CFG_MOUSE_CODE:  mouse_code_q  = cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
                expected_results.push_back(apply_item(event_item));
            pending = expected_results.size();
        end
    end

endmodule

// File: sim/tb_coalescing_event_queue.sv
// ----------------------------------------------------------------------------
// tb_coalescing_event_queue
// Drives the coalescing event queue with a short directed sequence and then
// random post/poll traffic over several type-code settings, with random idle
// bursts on both queue sides, one long consumer hold-off and drains between
// phases. Result checking is done by ceq_result_check.
// ----------------------------------------------------------------------------
module tb_coalescing_event_queue;

    localparam int RING_DEPTH     = 32;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 115;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 5000;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               push = 1'b0;
    logic                               full;
    ceq_pkg::in_item_t                  event_item = '0;
    logic                               empty;
    logic                               pop = 1'b0;
    ceq_pkg::out_item_t                 result;
    logic                               cfg_write = 1'b0;
    logic [ceq_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [ceq_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    int         fail_count;
    int         pending;
    int         stall_cycles = 0;
    bit         idle_on = 1'b1;
    bit         rx_hold_req = 1'b0;
    logic [7:0] cur_resize = ceq_pkg::RESIZE_CODE_RESET;
    logic [7:0] cur_mouse = ceq_pkg::MOUSE_CODE_RESET;

    // per-phase settings; a code of -1 is drawn at random
    int phase_resize [NUM_PHASES] = '{1, 0, 255, 7, 7, -1, 0, 255, -1, 1};
    int phase_mouse  [NUM_PHASES] = '{2, 255, 0, 7, 7, -1, 0, 255, -1, 2};
    int phase_posts  [NUM_PHASES] = '{90, 40, 90, 90, 40, 90, 60, 90, 40, 70};

    coalescing_event_queue #(
        .RING_DEPTH (RING_DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .event_item (event_item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    ceq_result_check #(
        .RING_DEPTH (RING_DEPTH)
    ) result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .event_item (event_item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("coalescing_event_queue test failed");
                $finish;
            end
        end
    end

    function automatic ceq_pkg::in_item_t make_item(logic op, logic [7:0] kind,
                                                    logic [15:0] key,
                                                    logic [11:0] x, logic [11:0] y,
                                                    logic [7:0] btn);
        ceq_pkg::in_item_t it;
        it.operation   = op;
        it.event_kind  = kind;
        it.key_code    = key;
        it.pos_x       = x;
        it.pos_y       = y;
        it.button_bits = btn;
        return it;
    endfunction

    // kinds lean toward the current resize and mouse codes
    function automatic ceq_pkg::in_item_t random_item(int post_pct);
        logic [7:0] kind;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            kind = cur_resize;
        else if (pick < 7)
            kind = cur_mouse;
        else
            kind = 8'($urandom);
        return make_item(($urandom_range(0, 99) < post_pct) ?
                         ceq_pkg::OP_POST : ceq_pkg::OP_POLL,
                         kind, 16'($urandom), 12'($urandom), 12'($urandom),
                         8'($urandom));
    endfunction

    // push stays high after the transfer so back-to-back items need no toggle
    task automatic send_item(ceq_pkg::in_item_t it);
        push <= 1'b1;
        event_item <= it;
        do @(posedge clk); while (full);
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_codes(logic [7:0] rcode, logic [7:0] mcode);
        cfg_write <= 1'b1;
        cfg_index <= ceq_pkg::CFG_RESIZE_CODE;
        cfg_data  <= rcode;
        @(posedge clk);
        cfg_index <= ceq_pkg::CFG_MOUSE_CODE;
        cfg_data  <= mcode;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_resize = rcode;
        cur_mouse  = mcode;
        @(posedge clk);
    endtask

    // consumer: random pop bursts, plus one long hold-off on request
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        ceq_pkg::in_item_t directed [$];
        int                p;
        int                n;
        logic [7:0]        rcode;
        logic [7:0]        mcode;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset codes: resize 1, mouse 2
        directed.push_back(make_item(ceq_pkg::OP_POLL, 8'd0, 16'h0000, 12'h000, 12'h000,
                                     8'h00));
        directed.push_back(make_item(ceq_pkg::OP_POST, 8'd1, 16'h0000, 12'h800, 12'h7ff,
                                     8'h00));
        directed.push_back(make_item(ceq_pkg::OP_POST, 8'd1, 16'hffff, 12'h7ff, 12'h800,
                                     8'hff));
        directed.push_back(make_item(ceq_pkg::OP_POST, 8'd2, 16'hffff, 12'hfff, 12'h000,
                                     8'hff));
        directed.push_back(make_item(ceq_pkg::OP_POST, 8'd2, 16'h0000, 12'h000, 12'hfff,
                                     8'h00));
        directed.push_back(make_item(ceq_pkg::OP_POST, 8'd0, 16'h0000, 12'h000, 12'h000,
                                     8'h00));
        directed.push_back(make_item(ceq_pkg::OP_POST, 8'd255, 16'hffff, 12'h7ff, 12'h7ff,
                                     8'hff));
        directed.push_back(make_item(ceq_pkg::OP_POST, 8'd2, 16'h1234, 12'h800, 12'h800,
                                     8'h5a));
        directed.push_back(make_item(ceq_pkg::OP_POST, 8'd1, 16'h4321, 12'h123, 12'h456,
                                     8'ha5));
        for (n = 0; n < 6; n++)
            directed.push_back(make_item(ceq_pkg::OP_POLL, 8'd0, 16'h0000, 12'h000,
                                         12'h000, 8'h00));
        directed.push_back(make_item(ceq_pkg::OP_POLL, 8'hff, 16'hffff, 12'hfff, 12'hfff,
                                     8'hff));
        foreach (directed[i])
        begin
            send_item(directed[i]);
            sender_gap();
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            rcode = (phase_resize[p] < 0) ? 8'($urandom_range(0, 255)) : 8'(phase_resize[p]);
            mcode = (phase_mouse[p] < 0) ? 8'($urandom_range(0, 255)) : 8'(phase_mouse[p]);
            write_codes(rcode, mcode);
            idle_on = (p != NUM_PHASES - 1) && (p % 3 != 2);
            // first phase: consumer stalls while the producer keeps offering
            if (p == 0)
                rx_hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(random_item(phase_posts[p]));
                sender_gap();
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("coalescing_event_queue test passed");
        else
            $display("coalescing_event_queue test failed");
        $finish;
    end

endmodule
